// ===== design/mdr_pkg.sv =====
// Shared types, widths and constants for the motion and daylight relay controller.
package mdr_pkg;

   // Field widths
   localparam int LIGHT_W = 12;
   localparam int GAP_W   = 12;
   localparam int WAIT_W  = 16;
   localparam int HOLD_W  = 24;
   localparam int TIME_W  = 32;
   localparam int DEC_W   = 3;

   // Milliseconds per second, used to turn the off wait into milliseconds
   localparam int MS_PER_S  = 1000;
   // Wide enough for the largest off wait in milliseconds (65535 * 1000)
   localparam int WAIT_MS_W = 26;

   // Stream widths, packed fields filled up to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LIGHT_THRESHOLD = 2'd0,
      CSR_HYSTERESIS_GAP      = 2'd1,
      CSR_OFF_WAIT_SECONDS    = 2'd2,
      CSR_DAYLIGHT_HOLD_MS    = 2'd3
   } csr_index_type;

   // Register values after reset
   localparam logic [LIGHT_W-1:0]   RST_THRESHOLD   = 12'd500;
   localparam logic [GAP_W-1:0]     RST_GAP         = 12'd20;
   localparam logic [WAIT_MS_W-1:0] RST_OFF_WAIT_MS = 26'd60000;
   localparam logic [HOLD_W-1:0]    RST_HOLD_MS     = 24'd60000;

   typedef enum logic [DEC_W-1:0] {
      DEC_MOTION_KEEPS_ON   = 3'd0,
      DEC_MOTION_TURNS_ON   = 3'd1,
      DEC_WAIT_EXPIRED_OFF  = 3'd2,
      DEC_DARK_WAITING      = 3'd3,
      DEC_BRIGHT_TIMING     = 3'd4,
      DEC_BRIGHT_STARTED    = 3'd5,
      DEC_BRIGHT_OFF        = 3'd6,
      DEC_BRIGHT_IDLE       = 3'd7
   } decision_type;

   // Settings as seen by the evaluation logic
   typedef struct packed {
      logic [LIGHT_W-1:0]   threshold;
      logic [GAP_W-1:0]     gap;
      logic [WAIT_MS_W-1:0] off_wait_ms;
      logic [HOLD_W-1:0]    hold_ms;
   } cfg_type;

   // One evaluation item
   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic               pir_motion;
      logic               radar_motion;
      logic [LIGHT_W-1:0] light_level;
   } req_item_type;

   // One result item
   typedef struct packed {
      decision_type decision;
      logic         relay_changed;
      logic         relay_on;
   } rsp_item_type;

endpackage

// ===== design/mdr_csr.sv =====
// Configuration registers of the relay controller, off wait kept in milliseconds.
module mdr_csr
   import mdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; scale the off wait to milliseconds as it is stored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOW_LIGHT_THRESHOLD: cfg_in.threshold = csr_wdata[LIGHT_W-1:0];
            CSR_HYSTERESIS_GAP:      cfg_in.gap       = csr_wdata[GAP_W-1:0];
            CSR_OFF_WAIT_SECONDS:    cfg_in.off_wait_ms =
               WAIT_MS_W'(csr_wdata[WAIT_W-1:0]) * WAIT_MS_W'(MS_PER_S);
            CSR_DAYLIGHT_HOLD_MS:    cfg_in.hold_ms   = csr_wdata[HOLD_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= RST_THRESHOLD;
         cfg_ff.gap         <= RST_GAP;
         cfg_ff.off_wait_ms <= RST_OFF_WAIT_MS;
         cfg_ff.hold_ms     <= RST_HOLD_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/mdr_core.sv =====
// Relay decision logic and the relay and timer state it updates per item.
module mdr_core
   import mdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic              relay_ff, relay_in;
   logic [TIME_W-1:0] off_start_ff, off_start_in;
   logic [TIME_W-1:0] day_start_ff, day_start_in;

   logic                      motion;
   logic                      dark;
   logic signed [LIGHT_W:0]   light_s;
   logic signed [LIGHT_W:0]   on_thr_s;
   logic [TIME_W-1:0]         wait_end;
   logic [TIME_W-1:0]         day_stamp;
   logic [TIME_W-1:0]         day_end;
   decision_type              decision;

   // Judge darkness; threshold drops by the gap while the relay is on
   always_comb begin
      light_s  = $signed({1'b0, item.light_level});
      on_thr_s = $signed({1'b0, cfg.threshold}) - $signed({1'b0, cfg.gap});
      if (relay_ff) begin
         dark = light_s > on_thr_s;
      end else begin
         dark = item.light_level > cfg.threshold;
      end
      motion = item.radar_motion | item.pir_motion;
   end

   // Timer end points, wrapping at 32 bits
   always_comb begin
      wait_end  = TIME_W'(cfg.off_wait_ms) + off_start_ff;
      day_stamp = (day_start_ff == '0) ? item.now_ms : day_start_ff;
      day_end   = day_stamp + TIME_W'(cfg.hold_ms);
   end

   // Decide and form the next state
   always_comb begin
      relay_in     = relay_ff;
      off_start_in = off_start_ff;
      day_start_in = day_start_ff;
      decision     = DEC_BRIGHT_IDLE;
      if (dark) begin
         day_start_in = '0;
         if (motion) begin
            decision     = relay_ff ? DEC_MOTION_KEEPS_ON : DEC_MOTION_TURNS_ON;
            relay_in     = 1'b1;
            off_start_in = item.now_ms;
         end else if (relay_ff && (wait_end < item.now_ms)) begin
            decision = DEC_WAIT_EXPIRED_OFF;
            relay_in = 1'b0;
         end else begin
            decision = DEC_DARK_WAITING;
         end
      end else if (relay_ff) begin
         day_start_in = day_stamp;
         decision     = (day_start_ff == '0) ? DEC_BRIGHT_STARTED : DEC_BRIGHT_TIMING;
         if (day_end < item.now_ms) begin
            decision = DEC_BRIGHT_OFF;
            relay_in = 1'b0;
         end
      end
   end

   // Advance the state when an item is evaluated
   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff     <= 1'b0;
         off_start_ff <= '0;
         day_start_ff <= '0;
      end else if (fire) begin
         relay_ff     <= relay_in;
         off_start_ff <= off_start_in;
         day_start_ff <= day_start_in;
      end
   end

   assign result.relay_on      = relay_in;
   assign result.relay_changed = relay_in ^ relay_ff;
   assign result.decision      = decision;

endmodule

// ===== design/motion_daylight_relay_controller_unit.sv =====
// Top level of the motion and daylight relay controller: item registers and handshake.
//
// Usage:
//   req_ channel takes one evaluation item (light sample, two motion bits,
//   millisecond timestamp); rsp_ channel returns one result item per input
//   item with the relay drive, a changed flag and a decision code.
//   csr_ port writes the four settings; write only while no item is in flight.
// Pipeline and throughput:
//   An accepted item is evaluated from the input register and its result is
//   written to the result register and shown on rsp_ once that register is
//   free. One item per cycle is taken and returned while rsp_tready stays
//   high; the evaluation is a single add and compare per timer between
//   the input register and the result register.
// Reset:
//   Relay off, both timer stamps cleared, settings back to their defaults,
//   both registers empty.
// Stall:
//   While rsp_tready is low the result is held; the input register still
//   takes one more item, after which req_tready drops until the result moves.
module motion_daylight_relay_controller_unit
   import mdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: light_level[11:0], radar_motion[12], pir_motion[13], now_ms[45:14]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: relay_on[0], relay_changed[1], decision[4:2]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   req_item_type item_ff;
   logic         item_valid_ff;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         advance;

   mdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mdr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Move an item to the result register when that register is empty or being read
   assign advance    = item_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~item_valid_ff | advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
      end
   end

   // Result register; hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

endmodule

// ===== sim/mdr_relay_checker.sv =====
`timescale 1ns / 1ps
// Checker for the relay controller: watches all three ports, predicts each result and compares it.
module mdr_relay_checker
   import mdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    results_checked,
   output logic [7:0]            decisions_seen
);

   // Settings as last written on the configuration port
   logic [LIGHT_W-1:0] dark_thr;
   logic [GAP_W-1:0]   dark_gap;
   logic [WAIT_W-1:0]  off_wait_s;
   logic [HOLD_W-1:0]  day_hold_ms;

   // Predicted controller state
   logic               lamp_on;
   logic [TIME_W-1:0]  off_stamp;
   logic [TIME_W-1:0]  day_stamp;

   // Relay results still due on the result channel, oldest first
   rsp_item_type       relay_q[$];

   int                 fails;
   int                 checked;
   logic [7:0]         seen_mask;

   // Evaluate one item against the predicted state and advance that state
   function automatic rsp_item_type predict_relay(input req_item_type it);
      rsp_item_type      res;
      logic              was_on;
      logic              motion;
      logic              dark;
      int                dark_level;
      logic [TIME_W-1:0] deadline;
      was_on     = lamp_on;
      motion     = it.radar_motion | it.pir_motion;
      // While lit, the threshold drops by the gap; the difference may go negative
      dark_level = was_on ? int'(dark_thr) - int'(dark_gap) : int'(dark_thr);
      dark       = int'(it.light_level) > dark_level;
      res.decision = DEC_BRIGHT_IDLE;
      if (dark) begin
         day_stamp = '0;
         if (motion) begin
            res.decision = was_on ? DEC_MOTION_KEEPS_ON : DEC_MOTION_TURNS_ON;
            lamp_on      = 1'b1;
            off_stamp    = it.now_ms;
         end else begin
            deadline = off_stamp + 32'(off_wait_s) * 32'(MS_PER_S);
            if (was_on && deadline < it.now_ms) begin
               res.decision = DEC_WAIT_EXPIRED_OFF;
               lamp_on      = 1'b0;
            end else begin
               res.decision = DEC_DARK_WAITING;
            end
         end
      end else if (was_on) begin
         res.decision = DEC_BRIGHT_TIMING;
         // A zero stamp counts as unset, so it is taken again
         if (day_stamp == '0) begin
            res.decision = DEC_BRIGHT_STARTED;
            day_stamp    = it.now_ms;
         end
         deadline = day_stamp + 32'(day_hold_ms);
         if (deadline < it.now_ms) begin
            res.decision = DEC_BRIGHT_OFF;
            lamp_on      = 1'b0;
         end
      end
      res.relay_on      = lamp_on;
      res.relay_changed = lamp_on != was_on;
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_item_type got;
      rsp_item_type want;
      req_item_type item;
      if (reset) begin
         dark_thr    = RST_THRESHOLD;
         dark_gap    = RST_GAP;
         off_wait_s  = 16'd60;
         day_hold_ms = RST_HOLD_MS;
         lamp_on     = 1'b0;
         off_stamp   = '0;
         day_stamp   = '0;
         relay_q.delete();
         fails       = 0;
         checked     = 0;
         seen_mask   = '0;
      end else begin
         // Track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_LIGHT_THRESHOLD: dark_thr    = csr_wdata[LIGHT_W-1:0];
               CSR_HYSTERESIS_GAP:      dark_gap    = csr_wdata[GAP_W-1:0];
               CSR_OFF_WAIT_SECONDS:    off_wait_s  = csr_wdata[WAIT_W-1:0];
               CSR_DAYLIGHT_HOLD_MS:    day_hold_ms = csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
         // Compare a result item with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
            if (relay_q.size() == 0) begin
               $error("result item with nothing pending: tdata %h", rsp_tdata);
               fails++;
            end else begin
               want = relay_q.pop_front();
               if (got.relay_on !== want.relay_on) begin
                  $error("relay_on: expected %0d, actual %0d", want.relay_on, got.relay_on);
                  fails++;
               end
               if (got.relay_changed !== want.relay_changed) begin
                  $error("relay_changed: expected %0d, actual %0d",
                         want.relay_changed, got.relay_changed);
                  fails++;
               end
               if (got.decision !== want.decision) begin
                  $error("decision: expected %0d, actual %0d", want.decision, got.decision);
                  fails++;
               end
               checked++;
               seen_mask[want.decision] = 1'b1;
            end
         end
         // Predict the result of an accepted item
         if (req_tvalid && req_tready) begin
            item = req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
            relay_q.push_back(predict_relay(item));
         end
      end
      fail_count      <= fails;
      pending_count   <= relay_q.size();
      results_checked <= checked;
      decisions_seen  <= seen_mask;
   end

endmodule

// ===== sim/tb_motion_daylight_relay_controller_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the relay controller: clock, reset, stimulus, result back-pressure and verdict.
module tb_motion_daylight_relay_controller_unit;
   import mdr_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_CYCLES = 60;
   localparam int LIGHT_MAX    = (1 << LIGHT_W) - 1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   int                    fail_count;
   int                    pending_count;
   int                    results_checked;
   logic [7:0]            decisions_seen;

   int                    send_idle_pct = 0;
   int                    rsp_idle_pct  = 0;
   int                    stall_req     = 0;
   int                    idle_cycles   = 0;
   int                    items_sent    = 0;
   int                    phases_run    = 0;

   // Current settings, used to steer the random items towards the edges
   logic [LIGHT_W-1:0]    cur_thr    = RST_THRESHOLD;
   logic [GAP_W-1:0]      cur_gap    = RST_GAP;
   logic [WAIT_W-1:0]     cur_wait_s = 16'd60;
   logic [HOLD_W-1:0]     cur_hold   = RST_HOLD_MS;
   logic [TIME_W-1:0]     sim_now_ms = '0;
   logic [LIGHT_W-1:0]    last_light = '0;

   motion_daylight_relay_controller_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mdr_relay_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .decisions_seen  (decisions_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Offer one item, with random idle cycles first, and hold it until taken
   task automatic send_item(input logic [LIGHT_W-1:0] light, input logic radar,
                            input logic pir, input logic [TIME_W-1:0] now);
      req_item_type it;
      it.light_level  = light;
      it.radar_motion = radar;
      it.pir_motion   = pir;
      it.now_ms       = now;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(it);
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Stop offering and wait until every result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back while the block is idle
   task automatic apply_settings(input logic [LIGHT_W-1:0] thr, input logic [GAP_W-1:0] gap,
                                 input logic [WAIT_W-1:0] ws, input logic [HOLD_W-1:0] hold);
      drain_results();
      cur_thr    = thr;
      cur_gap    = gap;
      cur_wait_s = ws;
      cur_hold   = hold;
      csr_we    <= 1'b1;
      csr_index <= CSR_LOW_LIGHT_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_index <= CSR_HYSTERESIS_GAP;
      csr_wdata <= CSR_DATA_W'(gap);
      @(posedge clock);
      csr_index <= CSR_OFF_WAIT_SECONDS;
      csr_wdata <= CSR_DATA_W'(ws);
      @(posedge clock);
      csr_index <= CSR_DAYLIGHT_HOLD_MS;
      csr_wdata <= CSR_DATA_W'(hold);
      @(posedge clock);
      csr_we    <= 1'b0;
      phases_run++;
   endtask

   // Advance time mostly on the scale of the timers, light often near the threshold or repeated
   task automatic send_random_item();
      int                 span;
      int                 lo;
      int                 hi;
      int                 kind;
      logic [LIGHT_W-1:0] light;
      span = int'(cur_wait_s) * MS_PER_S;
      if (int'(cur_hold) > span) span = int'(cur_hold);
      kind = $urandom_range(19);
      if (kind == 0)
         sim_now_ms = $urandom;
      else if (kind == 1)
         sim_now_ms = 32'hFFFF_FFFF - $urandom_range(span / 4 + 4);
      else if (kind == 2)
         sim_now_ms = '0;
      else if (kind < 7)
         sim_now_ms += $urandom_range(3);
      else
         sim_now_ms += $urandom_range(span + span / 2 + 2);
      lo = int'(cur_thr) - int'(cur_gap) - 8;
      hi = int'(cur_thr) + 8;
      if (lo < 0) lo = 0;
      if (hi > LIGHT_MAX) hi = LIGHT_MAX;
      kind = $urandom_range(9);
      if (kind < 3)
         light = last_light;
      else if (kind < 7)
         light = LIGHT_W'($urandom_range(hi, lo));
      else if (kind == 7)
         light = '0;
      else if (kind == 8)
         light = LIGHT_W'(LIGHT_MAX);
      else
         light = LIGHT_W'($urandom);
      last_light = light;
      send_item(light, $urandom_range(9) < 3, $urandom_range(9) < 3, sim_now_ms);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_random_item();
   endtask

   // Result side: random back-pressure, plus one long hold-off on request
   initial begin : rsp_side
      int stall_served;
      int n;
      stall_served = 0;
      forever begin
         @(posedge clock);
         if (stall_req != stall_served) begin
            stall_served = stall_req;
            rsp_tready <= 1'b0;
            for (n = 0; n < STALL_CYCLES; n++) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Give up when no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Sender idles a little, receiver a lot
      send_idle_pct = 10;
      rsp_idle_pct <= 80;

      // Directed items on the reset settings: hysteresis, both timers, zero stamp, wrap
      send_item(12'd0,    1'b0, 1'b0, 32'd100);
      send_item(12'(LIGHT_MAX), 1'b0, 1'b0, 32'd200);
      send_item(12'(LIGHT_MAX), 1'b1, 1'b0, 32'd300);
      send_item(12'(LIGHT_MAX), 1'b0, 1'b1, 32'd400);
      send_item(12'd490,  1'b0, 1'b0, 32'd500);
      send_item(12'd481,  1'b1, 1'b1, 32'd600);
      send_item(12'd480,  1'b0, 1'b0, 32'd700);
      send_item(12'd0,    1'b0, 1'b0, 32'd800);
      send_item(12'd0,    1'b1, 1'b1, 32'd60701);
      send_item(12'd0,    1'b0, 1'b0, 32'd60800);
      send_item(12'd900,  1'b1, 1'b0, 32'd61000);
      send_item(12'd900,  1'b0, 1'b0, 32'd121000);
      send_item(12'd900,  1'b0, 1'b0, 32'd121001);
      send_item(12'd900,  1'b0, 1'b1, 32'd200000);
      send_item(12'd10,   1'b0, 1'b0, 32'd0);
      send_item(12'd10,   1'b0, 1'b0, 32'd0);
      send_item(12'd10,   1'b0, 1'b0, 32'd1);
      send_item(12'(LIGHT_MAX), 1'b1, 1'b0, 32'hFFFF_FF00);
      send_item(12'(LIGHT_MAX), 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_item(12'(LIGHT_MAX), 1'b1, 1'b1, 32'hFFFF_FFF0);
      send_item(12'd0,    1'b0, 1'b0, 32'hFFFF_FFF1);
      send_item(12'd500,  1'b0, 1'b0, 32'h5555_5555);
      send_item(12'd501,  1'b0, 1'b0, 32'hAAAA_AAAA);
      sim_now_ms = 32'd1000;

      apply_settings(12'($urandom_range(3000, 100)), 12'($urandom_range(200)),
                     16'($urandom_range(5, 1)), 24'($urandom_range(5000, 500)));
      run_random(120);

      // Sender idles a lot, receiver a little; a gap above the threshold, zero timers
      send_idle_pct = 80;
      rsp_idle_pct <= 10;
      apply_settings(12'd0, 12'(LIGHT_MAX), 16'd0, 24'd0);
      run_random(110);

      // No idling; longest timers, with one long hold-off on the result side
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      apply_settings(12'd0, 12'd0, 16'hFFFF, 24'hFF_FFFF);
      stall_req <= stall_req + 1;
      run_random(110);

      apply_settings(12'(LIGHT_MAX), 12'(LIGHT_MAX), 16'($urandom_range(3)),
                     24'($urandom_range(2000)));
      run_random(40);

      apply_settings(12'($urandom), 12'($urandom), 16'($urandom), 24'($urandom));
      run_random(170);

      drain_results();
      $display("Sent %0d items across %0d register settings, with idling on both sides",
               items_sent, phases_run);
      $display("Checked %0d results; decision codes seen (one bit per code): %b",
               results_checked, decisions_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
